FILE: src/drr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drr_pkg
// Shared widths and defaults for the dense rank relabeler.
// ----------------------------------------------------------------------------
package drr_pkg;

  localparam int VALUE_W       = 32;  // signed element width
  localparam int RANK_W        = 6;   // rank field width
  localparam int OUT_TDATA_W   = 8;   // rank padded to a whole byte
  localparam int MAX_ITEMS_DEF = 64;  // default store capacity

endpackage

FILE: src/dense_rank_relabel_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_rank_relabel_top
// Loads a set of signed values into a single-port-read store, then emits the
// dense rank of every stored value in input order.
// ----------------------------------------------------------------------------
// Load: a word stored at index c > 0 is compared against each earlier entry,
//   one compare per entry, then its first-occurrence flag is written back; a
//   word stored at index 0, or dropped because the store is full, needs no scan.
// Emit: each result takes a key read and latch, a scan over all n stored words
//   and a hand-off that waits while the output register is full; one set at a time.
// Reset: synchronous, active low; clears control state. Store entries, their
//   first-occurrence flags included, are rewritten before they are read.
module dense_rank_relabel_top #(
  parameter int MAX_ITEMS = drr_pkg::MAX_ITEMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [drr_pkg::VALUE_W-1:0]     in_tdata,   // [31:0] value
  input  logic                            in_tlast,   // last_item
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [drr_pkg::OUT_TDATA_W-1:0] out_tdata,  // [5:0] rank, [7:6] zero
  output logic                            out_tlast,  // last_result
  output logic                            out_tuser   // overflow
);

  localparam int IDX_W   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int ENTRY_W = drr_pkg::VALUE_W + 1;  // {first flag, value}

  typedef enum logic [2:0] {
    ST_IDLE,   // accept words
    ST_DUP,    // compare new word against earlier entries
    ST_RKEY,   // read the entry to rank
    ST_RKEYW,  // latch the entry to rank
    ST_RSCAN,  // count distinct smaller entries
    ST_REMIT   // hand the rank to the output register
  } state_t;

  state_t state_r;

  // value store, first-occurrence flag in the top bit
  logic [ENTRY_W-1:0]          mem [MAX_ITEMS];
  logic [ENTRY_W-1:0]          rd_data_r;
  logic [IDX_W-1:0]            rd_addr;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [ENTRY_W-1:0]          wr_data;
  logic                        dup_wr;

  // control and datapath registers
  logic [CNT_W-1:0]            count_r;
  logic                        ovf_r;
  logic                        last_r;
  logic [drr_pkg::VALUE_W-1:0] key_r;
  logic [IDX_W-1:0]            cur_idx_r;
  logic [IDX_W-1:0]            i_r;
  logic [CNT_W-1:0]            sc_r;
  logic                        vld_r;
  logic                        dup_r;
  logic [drr_pkg::RANK_W-1:0]  acc_r;

  // output register
  logic                        out_valid_r;
  logic [drr_pkg::RANK_W-1:0]  out_rank_r;
  logic                        out_last_r;
  logic                        out_ovf_r;

  logic                        in_acc;
  logic                        full;
  logic [CNT_W-1:0]            scan_end;
  logic                        issue;
  logic                        scan_done;
  logic                        out_free;
  logic                        is_final;
  logic                        emit;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign full       = (count_r >= CNT_W'(MAX_ITEMS));

  // write the new word on accept, then its first-occurrence flag after the scan
  assign dup_wr     = (state_r == ST_DUP) && scan_done;
  assign wr_en      = (in_acc && !full) || dup_wr;
  assign wr_addr    = dup_wr ? cur_idx_r : count_r[IDX_W-1:0];
  assign wr_data    = dup_wr ? {!dup_r, key_r} : {1'b1, in_tdata};

  // scan bound: earlier entries while loading, whole set while ranking
  assign scan_end   = (state_r == ST_DUP) ? CNT_W'(cur_idx_r) : count_r;
  assign issue      = ((state_r == ST_DUP) || (state_r == ST_RSCAN)) && (sc_r < scan_end);
  assign scan_done  = (sc_r >= scan_end) && !vld_r;
  assign rd_addr    = (state_r == ST_RKEY) ? i_r : sc_r[IDX_W-1:0];
  assign out_free   = !out_valid_r || out_tready;
  assign is_final   = ((CNT_W'(i_r) + CNT_W'(1)) == count_r);
  assign emit       = (state_r == ST_REMIT) && out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(drr_pkg::OUT_TDATA_W - drr_pkg::RANK_W){1'b0}}, out_rank_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // sequencer, scan pipeline and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      sc_r        <= '0;
      vld_r       <= 1'b0;
      dup_r       <= 1'b0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // load a new output word, or drop the current one once taken
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      // track the read in flight
      vld_r <= issue;
      if (issue) begin
        sc_r <= sc_r + CNT_W'(1);
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            last_r <= in_tlast;
            key_r  <= in_tdata;
            dup_r  <= 1'b0;
            sc_r   <= '0;
            i_r    <= '0;
            if (full) begin
              ovf_r   <= 1'b1;
              state_r <= in_tlast ? ST_RKEY : ST_IDLE;
            end else begin
              cur_idx_r <= count_r[IDX_W-1:0];
              count_r   <= count_r + CNT_W'(1);
              if (count_r == '0) begin
                state_r <= in_tlast ? ST_RKEY : ST_IDLE;
              end else begin
                state_r <= ST_DUP;
              end
            end
          end
        end

        ST_DUP: begin
          if (vld_r && (rd_data_r[drr_pkg::VALUE_W-1:0] == key_r)) begin
            dup_r <= 1'b1;
          end
          if (scan_done) begin
            state_r <= last_r ? ST_RKEY : ST_IDLE;
          end
        end

        ST_RKEY: begin
          state_r <= ST_RKEYW;
        end

        ST_RKEYW: begin
          key_r   <= rd_data_r[drr_pkg::VALUE_W-1:0];
          sc_r    <= '0;
          acc_r   <= '0;
          state_r <= ST_RSCAN;
        end

        ST_RSCAN: begin
          // count first occurrences strictly below the key
          if (vld_r && rd_data_r[drr_pkg::VALUE_W] &&
              ($signed(rd_data_r[drr_pkg::VALUE_W-1:0]) < $signed(key_r))) begin
            acc_r <= acc_r + drr_pkg::RANK_W'(1);
          end
          if (scan_done) begin
            state_r <= ST_REMIT;
          end
        end

        ST_REMIT: begin
          if (emit) begin
            out_rank_r <= acc_r;
            out_last_r <= is_final;
            out_ovf_r  <= ovf_r;
            if (is_final) begin
              count_r <= '0;
              ovf_r   <= 1'b0;
              state_r <= ST_IDLE;
            end else begin
              i_r     <= i_r + IDX_W'(1);
              state_r <= ST_RKEY;
            end
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dense rank relabeler. Streams sets of signed
// words into the block and predicts the dense rank of every stored word. It
// also predicts the last and overflow marks and checks each rank word in order.
// A short table of hand-picked sets comes first. Random sets follow: one exactly
// full set, one overflowing set, heavy duplicates, random idling on both sides
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CAPACITY    = drr_pkg::MAX_ITEMS_DEF;
  localparam int WORD_TARGET = 270;
  localparam int NO_PIN      = -1;

  // one expected rank word: rank, last mark, overflow mark
  typedef struct packed {
    logic [drr_pkg::RANK_W-1:0] rank;
    logic                       last;
    logic                       ovf;
  } rank_word_t;

  // one row of the directed table; pin is the rank known by inspection
  typedef struct packed {
    logic [31:0] value;
    logic        last;
    int          pin;
  } dir_row_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [drr_pkg::VALUE_W-1:0]     in_tdata   = '0;
  logic                            in_tlast   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [drr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tlast;
  logic                            out_tuser;

  // shadow copy of the current set
  logic signed [31:0] set_vals [CAPACITY];
  int                 set_pins [CAPACITY];
  int                 set_len  = 0;
  bit                 set_ovf  = 1'b0;

  rank_word_t ranks_due [$];
  int         mismatches = 0;
  int         ranks_seen = 0;
  int         words_in   = 0;
  int         set_idx    = 0;
  bit         steady_in  = 1'b0;
  int         hold_left  = 0;
  bit         hold_done  = 1'b0;

  // hand-picked sets: extremes, sign boundary, duplicates, alternating bits
  dir_row_t dir_rows [21] = '{
    '{32'h8000_0000, 1'b1, 0},
    '{32'h7FFF_FFFF, 1'b1, 0},
    '{32'h0000_0000, 1'b1, 0},
    '{32'h8000_0000, 1'b0, 0},
    '{32'h7FFF_FFFF, 1'b0, 2},
    '{32'hFFFF_FFFF, 1'b1, 1},
    '{32'h0000_0005, 1'b0, 0},
    '{32'h0000_0005, 1'b0, 0},
    '{32'h0000_0005, 1'b1, 0},
    '{32'h0000_0007, 1'b0, 2},
    '{32'hFFFF_FFF9, 1'b0, 0},
    '{32'h0000_0007, 1'b0, 2},
    '{32'h0000_0000, 1'b0, 1},
    '{32'hFFFF_FFF9, 1'b1, 0},
    '{32'hAAAA_AAAA, 1'b0, 0},
    '{32'h5555_5555, 1'b1, 1},
    '{32'h0000_0064, 1'b0, NO_PIN},
    '{32'hFFFF_FF9C, 1'b0, NO_PIN},
    '{32'h0000_0064, 1'b1, NO_PIN},
    '{32'h8000_0001, 1'b0, NO_PIN},
    '{32'h7FFF_FFFE, 1'b1, NO_PIN}
  };

  dense_rank_relabel_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #1 clk = ~clk;

  // count distinct set values strictly below entry idx
  function automatic logic [drr_pkg::RANK_W-1:0] dense_rank_of(int idx);
    int  count;
    bit  first;
    count = 0;
    for (int j = 0; j < set_len; j++) begin
      if (set_vals[j] < set_vals[idx]) begin
        first = 1'b1;
        for (int k = 0; k < j; k++) begin
          if (set_vals[k] == set_vals[j]) first = 1'b0;
        end
        if (first) count++;
      end
    end
    return count[drr_pkg::RANK_W-1:0];
  endfunction

  // fold one accepted word into the shadow set; on last, queue its ranks
  function automatic void absorb_word(logic [31:0] value, logic last, int pin);
    rank_word_t w;
    if (set_len < CAPACITY) begin
      set_vals[set_len] = value;
      set_pins[set_len] = pin;
      set_len++;
    end else begin
      set_ovf = 1'b1;
    end
    if (last) begin
      for (int i = 0; i < set_len; i++) begin
        w.rank = (set_pins[i] == NO_PIN) ? dense_rank_of(i)
                                         : set_pins[i][drr_pkg::RANK_W-1:0];
        w.last = (i == set_len - 1);
        w.ovf  = set_ovf;
        ranks_due.push_back(w);
      end
      set_len = 0;
      set_ovf = 1'b0;
    end
  endfunction

  // offer one word, idling at random first, and wait for the handshake
  task automatic send_word(logic [31:0] value, logic last, int pin);
    while (!steady_in && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_word(value, last, pin);
    words_in++;
  endtask

  // mix of duplicate-heavy small values, extremes and full-range words
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 35) return $urandom_range(6) - 3;
    if (r < 45) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  // stimulus: reset, directed table, then random sets
  initial begin
    logic [31:0] vals [80];
    logic [31:0] tmp;
    int          n;
    int          j;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].value, dir_rows[i].last, dir_rows[i].pin);
    end

    while (words_in < WORD_TARGET) begin
      set_idx++;
      steady_in = (set_idx >= 12 && set_idx < 17);
      if (set_idx == 3) begin
        // exactly full, all distinct: ranks span the whole field
        n = CAPACITY;
        for (int i = 0; i < n; i++) vals[i] = (i - 32) * 32'h0100_0003 + 32'd17;
        for (int i = n - 1; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = vals[i];
          vals[i] = vals[j];
          vals[j] = tmp;
        end
      end else if (set_idx == 8) begin
        // overflow: trailing words and the last word itself are dropped
        n = CAPACITY + 3;
        for (int i = 0; i < n; i++) vals[i] = pick_value();
      end else begin
        n = ($urandom_range(9) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 10);
        for (int i = 0; i < n; i++) vals[i] = pick_value();
      end
      for (int i = 0; i < n; i++) send_word(vals[i], i == n - 1, NO_PIN);
    end
    in_tvalid <= 1'b0;

    // drain, then give the block time to show any stray word
    while (ranks_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver: check each rank word, then choose the next ready value
  always @(posedge clk) begin : rx_side
    rank_word_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (ranks_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected rank word: tdata %h last %b ovf %b",
                 $time, out_tdata, out_tlast, out_tuser);
      end else begin
        due = ranks_due.pop_front();
        if (out_tdata !== {2'b00, due.rank} || out_tlast !== due.last ||
            out_tuser !== due.ovf) begin
          mismatches++;
          $display("%0t: rank word %0d mismatch: expected rank %0d last %b ovf %b,",
                   $time, ranks_seen, due.rank, due.last, due.ovf,
                   " got tdata %h last %b ovf %b", out_tdata, out_tlast, out_tuser);
        end
      end
      ranks_seen++;
    end
    // hold off once for a long stretch so the input side backs up
    if (!hold_done && ranks_seen >= 30 && out_tvalid) begin
      hold_left = 400;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (ranks_seen >= 200 && ranks_seen < 260) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 36);
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
src/drr_pkg.sv
src/dense_rank_relabel_top.sv
bench/tb_top.sv
